// ----- hw/rtl/bpa_pkg.sv -----
// Package for the bitmap page allocator: request codes, field widths,
// controller state type and default sizes.
// No dependencies; the top level and the checker import it.
package bpa_pkg;

    // Default geometry of the page bitmap.
    localparam int NUM_PAGES_DEF = 4096;
    localparam int WORD_BITS_DEF = 32;

    // Fixed widths of the request and result fields.
    localparam int FUNC_W      = 2;
    localparam int INDEX_W     = 12;
    localparam int COUNT_W     = 13;
    localparam int START_W     = 12;
    localparam int FREE_OUT_W  = 13;
    // Width that holds page_index + page_count without overflow.
    localparam int SUM_W       = COUNT_W + 1;

    // Packed stream widths, rounded up to whole bytes.
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 32;

    // Request kinds.
    localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CLAIM   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd2;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_DONE
    } state_t;

endpackage

// ----- hw/rtl/bpa_bitmap_mem.sv -----
// Used-bit bitmap storage: one synchronous RAM of bitmap words with a
// registered read port, plus one valid bit per word so unwritten words read all used.
// No package dependencies.
module bpa_bitmap_mem #(
    parameter int WORD_BITS = 32,
    parameter int NWORDS    = 128,
    parameter int AW        = 7
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rd_en,
    input  logic [AW-1:0]        rd_addr,
    output logic [WORD_BITS-1:0] rd_data,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  logic [WORD_BITS-1:0] wr_data
);

    logic [WORD_BITS-1:0] mem_reg [NWORDS];
    logic [WORD_BITS-1:0] q_reg;
    logic [NWORDS-1:0]    valid_reg;
    logic                 rd_valid_reg;

    // RAM array with one write and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            q_reg <= mem_reg[rd_addr];
        end
    end

    // Per-word valid bits; reset marks every word as never written.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // A word that was never written reads as all pages used.
    assign rd_data = rd_valid_reg ? q_reg : '1;

endmodule

// ----- hw/rtl/bpa_run_scan.sv -----
// First-fit run finder for one bitmap word: carries the free-run length in
// from the previous word and reports the first bit where the run is long enough.
// No package dependencies.
module bpa_run_scan #(
    parameter int WORD_BITS = 32,
    parameter int NUM_PAGES = 4096,
    parameter int AW        = 7,
    parameter int RUN_W     = 14
) (
    input  logic [AW-1:0]                  word_addr,
    input  logic [WORD_BITS-1:0]           rdata,
    input  logic [RUN_W-1:0]               run_in,
    input  logic [RUN_W-1:0]               need,
    output logic                           hit,
    output logic [$clog2(WORD_BITS)-1:0]   hit_bit,
    output logic [RUN_W-1:0]               run_out
);

    localparam int BIT_W = $clog2(WORD_BITS);

    logic [WORD_BITS-1:0] used_eff;
    logic [RUN_W-1:0]     run_b [WORD_BITS];

    // Page zero and pages past the top never join a run.
    always_comb
    begin
        for (int b = 0; b < WORD_BITS; b++)
        begin
            logic [31:0] pg;
            pg = (32'(word_addr) << BIT_W) + 32'(b);
            used_eff[b] = rdata[b] || (pg == 32'd0) || (pg >= 32'(NUM_PAGES));
        end
    end

    // Run length ending at each bit: since the last used bit in this word,
    // or the carried run plus the bits so far when the word is free below it.
    always_comb
    begin
        for (int b = 0; b < WORD_BITS; b++)
        begin
            logic found;
            int   last_idx;
            found    = 1'b0;
            last_idx = 0;
            for (int j = 0; j < WORD_BITS; j++)
            begin
                if (j <= b && used_eff[j])
                begin
                    found    = 1'b1;
                    last_idx = j;
                end
            end
            if (found)
            begin
                run_b[b] = RUN_W'(b - last_idx);
            end
            else
            begin
                run_b[b] = run_in + RUN_W'(b + 1);
            end
        end
    end

    // The lowest bit whose run reaches the requested length wins.
    always_comb
    begin
        hit     = 1'b0;
        hit_bit = '0;
        for (int b = 0; b < WORD_BITS; b++)
        begin
            if (!hit && run_b[b] >= need)
            begin
                hit     = 1'b1;
                hit_bit = BIT_W'(b);
            end
        end
        run_out = run_b[WORD_BITS-1];
    end

endmodule

// ----- hw/rtl/bpa_range_update.sv -----
// Read-modify-write datapath for one bitmap word: sets or clears the bits of
// a page range that fall in this word and counts the bits that flip.
// No package dependencies.
module bpa_range_update #(
    parameter int WORD_BITS = 32,
    parameter int NUM_PAGES = 4096,
    parameter int AW        = 7,
    parameter int RANGE_W   = 14,
    parameter int FLIP_W    = 6
) (
    input  logic [AW-1:0]        word_addr,
    input  logic [WORD_BITS-1:0] rdata,
    input  logic [RANGE_W-1:0]   lo,
    input  logic [RANGE_W-1:0]   hi,
    input  logic                 set_used,
    output logic [WORD_BITS-1:0] wdata,
    output logic [FLIP_W-1:0]    flips
);

    localparam int BIT_W = $clog2(WORD_BITS);

    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] diff;

    // Bits of this word inside [lo, hi) and below the top of memory.
    always_comb
    begin
        for (int b = 0; b < WORD_BITS; b++)
        begin
            logic [31:0] pg;
            pg = (32'(word_addr) << BIT_W) + 32'(b);
            mask[b] = (pg >= 32'(lo)) && (pg < 32'(hi)) && (pg < 32'(NUM_PAGES));
        end
    end

    // New word and the number of pages that actually change state.
    assign wdata = set_used ? (rdata | mask) : (rdata & ~mask);
    assign diff  = wdata ^ rdata;
    assign flips = FLIP_W'($countones(diff));

endmodule

// ----- hw/rtl/bitmap_page_allocator_unit.sv -----
// Top level of the bitmap page allocator: request sequencer, free-page counter
// and result register around the bitmap RAM.
// Depends on bpa_pkg, bpa_bitmap_mem, bpa_run_scan and bpa_range_update.
//
//  Channel  Direction  Signals                       Payload (low bit up)
//  s_*      in         s_tvalid s_tready s_tdata     func, page_index, page_count
//  m_*      out        m_tvalid m_tready m_tdata     ok, start_page, free_count
//
// Claim and release walk the bitmap words that the clamped range covers; an
// allocation runs the word-per-cycle scan through the RAM read port until a
// run is long enough or the last word is read, and a granted one then marks
// the words of the run. Rejected requests go straight to the done state.
// The input is ready again from the edge that offers the result.
// Reset clears the valid bits of all words at once, so the bitmap reads as all
// used and the free count is zero right after reset.
// A new request is taken while a finished result still waits in the output
// register; a stalled result holds the sequencer only when a second result is done.
module bitmap_page_allocator_unit
    import bpa_pkg::*;
#(
    parameter int NUM_PAGES = NUM_PAGES_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // s_tdata: [1:0] func, [13:2] page_index, [26:14] page_count, [31:27] zero
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // m_tdata: [0] ok, [12:1] start_page, [25:13] free_count, [31:26] zero
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    localparam int BIT_W   = $clog2(WORD_BITS);
    localparam int NWORDS  = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int AW      = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int PAGE_W  = $clog2(NUM_PAGES) + 1;
    localparam int RANGE_W = (PAGE_W > SUM_W) ? PAGE_W : SUM_W;
    localparam int RUN_W   = PAGE_W + 1;
    localparam int FREE_W  = $clog2(NUM_PAGES + 1);
    localparam int FLIP_W  = $clog2(WORD_BITS + 1);

    // Request fields.
    logic [FUNC_W-1:0]  in_func;
    logic [INDEX_W-1:0] in_index;
    logic [COUNT_W-1:0] in_count;

    assign in_func  = s_tdata[FUNC_W-1:0];
    assign in_index = s_tdata[FUNC_W+INDEX_W-1:FUNC_W];
    assign in_count = s_tdata[FUNC_W+INDEX_W+COUNT_W-1:FUNC_W+INDEX_W];

    // Sequencer registers.
    state_t               state_reg, state_next;
    logic [RUN_W-1:0]     need_reg, need_next;
    logic [RUN_W-1:0]     run_reg, run_next;
    logic [RANGE_W-1:0]   lo_reg, lo_next;
    logic [RANGE_W-1:0]   hi_reg, hi_next;
    logic                 set_used_reg, set_used_next;
    logic [AW:0]          rd_word_reg, rd_word_next;
    logic [AW-1:0]        last_word_reg, last_word_next;
    logic                 pend_reg, pend_next;
    logic [AW-1:0]        proc_word_reg, proc_word_next;
    logic [FREE_W-1:0]    free_reg, free_next;
    logic                 res_ok_reg, res_ok_next;
    logic [RANGE_W-1:0]   res_start_reg, res_start_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;

    // RAM and datapath connections.
    logic                 rd_en;
    logic [WORD_BITS-1:0] rd_data;
    logic                 wr_en;
    logic [WORD_BITS-1:0] wr_data;
    logic                 scan_hit;
    logic [BIT_W-1:0]     scan_bit;
    logic [RUN_W-1:0]     scan_run;
    logic [FLIP_W-1:0]    flips;

    // Decoded request values.
    logic                 accept;
    logic [RANGE_W-1:0]   req_lo;
    logic [RANGE_W-1:0]   req_hi_raw;
    logic [RANGE_W-1:0]   req_hi;
    logic [RANGE_W-1:0]   req_hi_m1;
    logic                 alloc_reject;
    logic                 range_empty;

    // Run found by the scan, as a page range.
    logic [31:0]          hit_start;
    logic [31:0]          hit_end;
    logic [31:0]          hit_last;

    logic                 scan_last_word;
    logic                 upd_last_word;
    logic                 out_free;
    logic [31:0]          free_ext;
    logic [31:0]          start_ext;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);

    assign req_lo       = RANGE_W'(in_index);
    assign req_hi_raw   = RANGE_W'(in_index) + RANGE_W'(in_count);
    assign req_hi       = (req_hi_raw > RANGE_W'(NUM_PAGES)) ? RANGE_W'(NUM_PAGES) : req_hi_raw;
    assign req_hi_m1    = req_hi - RANGE_W'(1);
    assign alloc_reject = (in_count == '0) || (32'(in_count) >= 32'(NUM_PAGES));
    assign range_empty  = (in_count == '0) || (32'(in_index) >= 32'(NUM_PAGES));

    assign hit_start = (32'(proc_word_reg) << BIT_W) + 32'(scan_bit) + 32'd1 - 32'(need_reg);
    assign hit_end   = hit_start + 32'(need_reg);
    assign hit_last  = hit_end - 32'd1;

    assign scan_last_word = (32'(proc_word_reg) == 32'(NWORDS - 1));
    assign upd_last_word  = (proc_word_reg == last_word_reg);
    assign out_free       = !m_tvalid_reg || m_tready;

    // RAM read issue: one word a cycle while the walk has words left.
    always_comb
    begin
        case (state_reg)
            ST_SCAN:   rd_en = (rd_word_reg < (AW+1)'(NWORDS));
            ST_UPDATE: rd_en = (rd_word_reg <= {1'b0, last_word_reg});
            default:   rd_en = 1'b0;
        endcase
    end

    assign wr_en = (state_reg == ST_UPDATE) && pend_reg;

    bpa_bitmap_mem #(
        .WORD_BITS (WORD_BITS),
        .NWORDS    (NWORDS),
        .AW        (AW)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_word_reg[AW-1:0]),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (proc_word_reg),
        .wr_data (wr_data)
    );

    bpa_run_scan #(
        .WORD_BITS (WORD_BITS),
        .NUM_PAGES (NUM_PAGES),
        .AW        (AW),
        .RUN_W     (RUN_W)
    ) u_scan (
        .word_addr (proc_word_reg),
        .rdata     (rd_data),
        .run_in    (run_reg),
        .need      (need_reg),
        .hit       (scan_hit),
        .hit_bit   (scan_bit),
        .run_out   (scan_run)
    );

    bpa_range_update #(
        .WORD_BITS (WORD_BITS),
        .NUM_PAGES (NUM_PAGES),
        .AW        (AW),
        .RANGE_W   (RANGE_W),
        .FLIP_W    (FLIP_W)
    ) u_upd (
        .word_addr (proc_word_reg),
        .rdata     (rd_data),
        .lo        (lo_reg),
        .hi        (hi_reg),
        .set_used  (set_used_reg),
        .wdata     (wr_data),
        .flips     (flips)
    );

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_func)
                        FUNC_ALLOC:   state_next = alloc_reject ? ST_DONE : ST_SCAN;
                        FUNC_CLAIM,
                        FUNC_RELEASE: state_next = range_empty ? ST_DONE : ST_UPDATE;
                        default:      state_next = ST_DONE;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (pend_reg && scan_hit)
                begin
                    state_next = ST_UPDATE;
                end
                else if (pend_reg && scan_last_word)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_UPDATE:
            begin
                if (pend_reg && upd_last_word)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and result values for each state.
    always_comb
    begin
        need_next      = need_reg;
        run_next       = run_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        set_used_next  = set_used_reg;
        rd_word_next   = rd_en ? rd_word_reg + (AW+1)'(1) : rd_word_reg;
        last_word_next = last_word_reg;
        pend_next      = rd_en;
        proc_word_next = rd_en ? rd_word_reg[AW-1:0] : proc_word_reg;
        free_next      = free_reg;
        res_ok_next    = res_ok_reg;
        res_start_next = res_start_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        out_data_next  = out_data_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    need_next      = RUN_W'(in_count);
                    run_next       = '0;
                    lo_next        = req_lo;
                    hi_next        = req_hi;
                    set_used_next  = (in_func != FUNC_RELEASE);
                    last_word_next = AW'(req_hi_m1 >> BIT_W);
                    pend_next      = 1'b0;
                    case (in_func)
                        FUNC_ALLOC:
                        begin
                            rd_word_next   = '0;
                            res_ok_next    = 1'b0;
                            res_start_next = '0;
                        end
                        FUNC_CLAIM,
                        FUNC_RELEASE:
                        begin
                            rd_word_next   = (AW+1)'(req_lo >> BIT_W);
                            res_ok_next    = 1'b1;
                            res_start_next = req_lo;
                        end
                        default:
                        begin
                            res_ok_next    = 1'b0;
                            res_start_next = req_lo;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (pend_reg)
                begin
                    run_next = scan_run;
                    if (scan_hit)
                    begin
                        // Hand the found run to the marking pass.
                        lo_next        = RANGE_W'(hit_start);
                        hi_next        = RANGE_W'(hit_end);
                        set_used_next  = 1'b1;
                        rd_word_next   = (AW+1)'(hit_start >> BIT_W);
                        last_word_next = AW'(hit_last >> BIT_W);
                        pend_next      = 1'b0;
                        res_ok_next    = 1'b1;
                        res_start_next = RANGE_W'(hit_start);
                    end
                end
            end
            ST_UPDATE:
            begin
                if (pend_reg)
                begin
                    if (set_used_reg)
                    begin
                        free_next = free_reg - FREE_W'(flips);
                    end
                    else
                    begin
                        free_next = free_reg + FREE_W'(flips);
                    end
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    out_data_next = OUT_TDATA_W'({free_ext[FREE_OUT_W-1:0],
                                                  start_ext[START_W-1:0],
                                                  res_ok_reg});
                end
            end
            default:
            begin
                pend_next = 1'b0;
            end
        endcase
    end

    assign free_ext  = 32'(free_reg);
    assign start_ext = 32'(res_start_reg);

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            pend_reg     <= 1'b0;
            free_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pend_reg     <= pend_next;
            free_reg     <= free_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        need_reg      <= need_next;
        run_reg       <= run_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        set_used_reg  <= set_used_next;
        rd_word_reg   <= rd_word_next;
        last_word_reg <= last_word_next;
        proc_word_reg <= proc_word_next;
        res_ok_reg    <= res_ok_next;
        res_start_reg <= res_start_next;
        out_data_reg  <= out_data_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ----- hw/rtl/bpa_checker.sv -----
// Port-level assertions for the bitmap page allocator and the bind that
// attaches them to the top level.
// Depends on bpa_pkg and bitmap_page_allocator_unit.
module bpa_checker
    import bpa_pkg::*;
#(
    parameter int NUM_PAGES = NUM_PAGES_DEF
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    localparam int RES_W = 1 + START_W + FREE_OUT_W;

    // The sequencer leaves idle only after it took a transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_tready) |-> $past(s_tvalid))
        else $error("input ready dropped without a transfer");

    // Padding above the result fields stays zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[OUT_TDATA_W-1:RES_W] == '0))
        else $error("result padding is not zero");

    // The free count never exceeds the number of pages.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (32'(m_tdata[RES_W-1:1+START_W]) <= 32'(NUM_PAGES)))
        else $error("free count above page total");

    // A stalled result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn while stalled");

    // A stalled result holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

endmodule

bind bitmap_page_allocator_unit bpa_checker #(.NUM_PAGES(NUM_PAGES)) u_bpa_checker (.*);
